FILE: hw/rtl/slt_pkg.sv
// Shared constants, codes and types for the sorted list table.
`default_nettype none
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam logic [1:0] ACT_HOLD   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_SHIFT  = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [4:0] COUNT_FULL = 5'(CAPACITY);

    typedef struct packed {
        logic [1:0]         act;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic               valid;
        logic               less;
        logic signed [31:0] entry;
    } t_link;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } t_lookup;

endpackage
`default_nettype wire

FILE: hw/rtl/slt_cell.sv
// One storage cell of the sorted row: compare with the broadcast value, shift either way.
`default_nettype none
module slt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire slt_pkg::t_cmd i_cmd,
    input  wire slt_pkg::t_link i_left,
    input  wire slt_pkg::t_link i_right,
    output slt_pkg::t_link     o_link,
    output logic               o_match,
    output logic               o_boundary
);

    logic               r_valid;
    logic signed [31:0] r_entry;
    logic               n_valid;
    logic signed [31:0] n_entry;
    logic               less;

    assign less       = r_valid && (r_entry < i_cmd.value);
    assign o_match    = r_valid && (r_entry == i_cmd.value);
    assign o_boundary = !less && i_left.less;
    assign o_link     = '{valid: r_valid, less: less, entry: r_entry};

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        case (i_cmd.act)
            slt_pkg::ACT_INSERT: begin
                if (!less) begin
                    if (i_left.less) begin
                        n_valid = 1'b1;
                        n_entry = i_cmd.value;
                    end else begin
                        n_valid = i_left.valid;
                        n_entry = i_left.entry;
                    end
                end
            end
            slt_pkg::ACT_SHIFT: begin
                if (!less) begin
                    n_valid = i_right.valid;
                    n_entry = i_right.entry;
                end
            end
            slt_pkg::ACT_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/slt_encode.sv
// Boundary encoder: index of the first cell not below the value, and hit detection.
`default_nettype none
module slt_encode (
    input  wire logic [slt_pkg::CAPACITY-1:0] i_boundary,
    input  wire logic [slt_pkg::CAPACITY-1:0] i_match,
    output slt_pkg::t_lookup                  o_lookup
);

    always_comb begin
        o_lookup = '0;
        for (int k = 0; k < slt_pkg::CAPACITY; k++) begin
            if (i_boundary[k]) begin
                o_lookup.found = o_lookup.found | i_match[k];
                o_lookup.index = o_lookup.index | slt_pkg::IDX_W'(k);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sorted_list_table.sv
// Top level of the sorted list table: command register, cell row and result register.
// An accepted command is registered, the cell row acts on it while busy is high, and the result
// register then raises o_valid. Start is accepted only while busy is low, one transaction at a time;
// busy is high for the cycle the command register drives the cell row, which compares and shifts in that cycle.
// Reset: synchronous, active low; empties the table and drops any pending transaction.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module sorted_list_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [3:0]              o_position,
    output logic [4:0]              o_count,
    output logic [1:0]              o_status
);

    localparam int N = slt_pkg::CAPACITY;

    logic                        r_busy;
    logic [1:0]                  r_op;
    logic signed [31:0]          r_val;
    logic [slt_pkg::CNT_W-1:0]   r_count;
    logic [slt_pkg::CNT_W-1:0]   n_count;
    logic                        r_valid;
    logic                        r_found;
    logic [3:0]                  r_position;
    logic [4:0]                  r_res_count;
    logic [1:0]                  r_status;

    logic                        n_found;
    logic [slt_pkg::IDX_W-1:0]   n_index;
    logic [1:0]                  n_status;
    logic                        full;

    slt_pkg::t_cmd               cmd;
    slt_pkg::t_link              links  [N+1];
    slt_pkg::t_link              rights [N];
    logic [N-1:0]                match;
    logic [N-1:0]                boundary;
    slt_pkg::t_lookup            lookup;

    logic [slt_pkg::IDX_W+3:0]   pos_ext;
    logic [slt_pkg::CNT_W+4:0]   cnt_ext;

    assign busy = r_busy;
    assign full = (r_count == slt_pkg::CNT_W'(N));

    assign links[0] = '{valid: 1'b0, less: 1'b1, entry: '0};

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            if (g == N - 1) begin : g_last
                assign rights[g] = '{valid: 1'b0, less: 1'b0, entry: '0};
            end else begin : g_mid
                assign rights[g] = links[g+2];
            end
            slt_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (cmd),
                .i_left     (links[g]),
                .i_right    (rights[g]),
                .o_link     (links[g+1]),
                .o_match    (match[g]),
                .o_boundary (boundary[g])
            );
        end
    endgenerate

    slt_encode u_encode (
        .i_boundary (boundary),
        .i_match    (match),
        .o_lookup   (lookup)
    );

    always_comb begin
        cmd.value = r_val;
        cmd.act   = slt_pkg::ACT_HOLD;
        n_count   = r_count;
        n_found   = 1'b0;
        n_index   = '0;
        n_status  = slt_pkg::ST_OK;
        if (r_busy) begin
            case (r_op)
                slt_pkg::OP_INSERT: begin
                    if (full) begin
                        n_status = slt_pkg::ST_FULL;
                    end else begin
                        cmd.act = slt_pkg::ACT_INSERT;
                        n_index = lookup.index;
                        n_count = r_count + slt_pkg::CNT_W'(1);
                    end
                end
                slt_pkg::OP_REMOVE, slt_pkg::OP_FIND: begin
                    if (lookup.found) begin
                        n_found = 1'b1;
                        n_index = lookup.index;
                        if (r_op == slt_pkg::OP_REMOVE) begin
                            cmd.act = slt_pkg::ACT_SHIFT;
                            n_count = r_count - slt_pkg::CNT_W'(1);
                        end
                    end else begin
                        n_status = slt_pkg::ST_MISSING;
                    end
                end
                slt_pkg::OP_CLEAR: begin
                    cmd.act = slt_pkg::ACT_CLEAR;
                    n_count = '0;
                end
                default: begin
                    cmd.act = slt_pkg::ACT_HOLD;
                end
            endcase
        end
    end

    assign pos_ext = {4'b0, n_index};
    assign cnt_ext = {5'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= start && !r_busy;
            r_valid <= r_busy;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_op  <= i_operation;
            r_val <= i_value;
        end
        if (r_busy) begin
            r_found     <= n_found;
            r_position  <= pos_ext[3:0];
            r_res_count <= cnt_ext[4:0];
            r_status    <= n_status;
        end
    end

    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_position;
    assign o_count    = r_res_count;
    assign o_status   = r_status;

endmodule
`default_nettype wire

FILE: hw/rtl/slt_checker.sv
// Port-level checker for the sorted list table, bound to the top level.
`default_nettype none
module slt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic        o_found,
    input wire logic [3:0]  o_position,
    input wire logic [4:0]  o_count,
    input wire logic [1:0]  o_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_valid)
        else $error("result strobe missing two cycles after accept");

    a_result_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && !$past(o_valid))
        else $error("result strobe overlaps busy or repeats");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == slt_pkg::ST_FULL) |->
            !o_found && (o_position == 4'd0) && (o_count == slt_pkg::COUNT_FULL))
        else $error("full result with wrong fields");

    a_missing_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == slt_pkg::ST_MISSING) |-> !o_found && (o_position == 4'd0))
        else $error("not-found result with found or position set");

endmodule

bind sorted_list_table slt_checker u_slt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_found    (o_found),
    .o_position (o_position),
    .o_count    (o_count),
    .o_status   (o_status)
);
`default_nettype wire
